@@ hw/rtl/road_proximity_lookup_top_macros.svh @@
// ----------------------------------------------------------------------------
// Road proximity lookup assertion macros
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ROAD_PROXIMITY_LOOKUP_TOP_MACROS_SVH
`define ROAD_PROXIMITY_LOOKUP_TOP_MACROS_SVH

// same-cycle implication
`define RPL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("road proximity lookup: check failed");

// next-cycle implication
`define RPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("road proximity lookup: check failed");

`endif

@@ hw/rtl/rpl_pkg.sv @@
// ----------------------------------------------------------------------------
// rpl_pkg
// Types and constants shared by the road proximity lookup modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpl_pkg;

    localparam int unsigned ADDR_W = 4;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_NEAR_LANE = 2'd0,
        REG_NEAR_EXIT = 2'd1,
        REG_OFFSET_X  = 2'd2,
        REG_OFFSET_Y  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // 1000 m in 1/64 m units, squared
    localparam logic [31:0] FAR_BOUND_SQ = 32'd4096000000;

    localparam logic [15:0] NEAR_DIST_RESET = 16'd128;

    typedef struct packed {
        op_t                operation;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [15:0] heading_in;
        logic               exit_flag;
    } cmd_t;

    typedef struct packed {
        logic               is_close;
        logic               road_found;
        logic signed [15:0] road_heading;
    } res_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] heading;
        logic               is_exit;
    } point_t;

    typedef struct packed {
        logic init;
        logic rd_en;
    } scan_ctrl_t;

    typedef struct packed {
        logic busy;
        res_t result;
    } scan_stat_t;

endpackage

@@ hw/rtl/rpl_point_mem.sv @@
// ----------------------------------------------------------------------------
// rpl_point_mem
// Point table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpl_point_mem #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  rpl_pkg::point_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output rpl_pkg::point_t rd_data
);

    rpl_pkg::point_t mem [DEPTH];
    rpl_pkg::point_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/rpl_scan.sv @@
// ----------------------------------------------------------------------------
// rpl_scan
// Distance pipeline and nearest-point accumulator for one query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpl_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rpl_pkg::scan_ctrl_t   ctrl,
    input  logic signed [31:0]    coord_x,
    input  logic signed [31:0]    coord_y,
    input  logic signed [31:0]    offset_x,
    input  logic signed [31:0]    offset_y,
    input  logic [15:0]           near_lane,
    input  logic [15:0]           near_exit,
    input  rpl_pkg::point_t       rd_data,
    output rpl_pkg::scan_stat_t   stat
);

    logic [32:0] qx_reg;
    logic [32:0] qy_reg;
    logic [31:0] lane2_reg;
    logic [31:0] exit2_reg;
    logic [31:0] rad2_reg;

    logic        v1_reg;
    logic        va_reg;
    logic        vb_reg;

    logic [15:0] ax_reg;
    logic [15:0] ay_reg;
    logic        reach_a_reg;
    logic [15:0] head_a_reg;
    logic        exit_a_reg;

    logic [31:0] sqx_reg;
    logic [31:0] sqy_reg;
    logic        reach_b_reg;
    logic [15:0] head_b_reg;
    logic        exit_b_reg;

    logic [31:0] best_reg;
    logic        close_reg;
    logic        found_reg;
    logic [15:0] head_reg;

    logic [33:0] dx;
    logic [33:0] dy;
    logic [33:0] adx;
    logic [33:0] ady;
    logic [32:0] d2;
    logic        hit;
    logic        better;
    logic        near_hit;

    // stage A: offset difference and reach check
    always_comb
    begin
        dx  = {{2{rd_data.x[31]}}, rd_data.x} - {qx_reg[32], qx_reg};
        dy  = {{2{rd_data.y[31]}}, rd_data.y} - {qy_reg[32], qy_reg};
        adx = dx[33] ? (34'd0 - dx) : dx;
        ady = dy[33] ? (34'd0 - dy) : dy;
    end

    // stage C: sum and compare
    always_comb
    begin
        d2       = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        hit      = vb_reg && reach_b_reg && (d2 < {1'b0, rad2_reg});
        better   = hit && (d2 < {1'b0, best_reg});
        near_hit = hit && ((d2 < {1'b0, lane2_reg})
                   || (exit_b_reg && (d2 < {1'b0, exit2_reg})));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            close_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.rd_en;
            va_reg <= v1_reg;
            vb_reg <= va_reg;
            if (ctrl.init)
            begin
                close_reg <= 1'b0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (near_hit)
                begin
                    close_reg <= 1'b1;
                end
                if (better)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rad2_reg <= (lane2_reg > exit2_reg) ? lane2_reg : exit2_reg;
        if (ctrl.init)
        begin
            qx_reg    <= {coord_x[31], coord_x} + {offset_x[31], offset_x};
            qy_reg    <= {coord_y[31], coord_y} + {offset_y[31], offset_y};
            lane2_reg <= 32'(near_lane) * 32'(near_lane);
            exit2_reg <= 32'(near_exit) * 32'(near_exit);
            best_reg  <= rpl_pkg::FAR_BOUND_SQ;
            head_reg  <= 16'd0;
        end
        else if (better)
        begin
            best_reg <= d2[31:0];
            head_reg <= head_b_reg;
        end

        ax_reg      <= adx[15:0];
        ay_reg      <= ady[15:0];
        reach_a_reg <= (adx[33:16] == 18'd0) && (ady[33:16] == 18'd0);
        head_a_reg  <= rd_data.heading;
        exit_a_reg  <= rd_data.is_exit;

        sqx_reg     <= 32'(ax_reg) * 32'(ax_reg);
        sqy_reg     <= 32'(ay_reg) * 32'(ay_reg);
        reach_b_reg <= reach_a_reg;
        head_b_reg  <= head_a_reg;
        exit_b_reg  <= exit_a_reg;
    end

    always_comb
    begin
        stat.busy                = v1_reg || va_reg || vb_reg;
        stat.result.is_close     = close_reg;
        stat.result.road_found   = found_reg;
        stat.result.road_heading = head_reg;
    end

endmodule

@@ hw/rtl/road_proximity_lookup_top.sv @@
// ----------------------------------------------------------------------------
// road_proximity_lookup_top
// Point table with fixed-radius nearest-point query over an APB-style
// register port.
// ----------------------------------------------------------------------------
// Clear and append items are handled in the idle state and do not stall the
// input. A query reads the point table one entry per cycle through the single
// read port of the point memory, passing through the scan, drain and done
// states; on an empty table it skips the scan. The input stalls until the
// query result is loaded into the output register, which waits while an older
// result is held off. A clear or append may be accepted while a result waits.
// The memory has no reset pass: entries at or above point_count are never read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module road_proximity_lookup_top #(
    parameter int unsigned MAX_POINTS = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  rpl_pkg::cmd_t              cmd,
    output logic                       res_valid,
    input  logic                       res_stall,
    output rpl_pkg::res_t              res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rpl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);

    rpl_pkg::state_t     state_reg;
    rpl_pkg::state_t     state_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       rd_addr_reg;
    logic [CW-1:0]       rd_addr_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    rpl_pkg::res_t       res_reg;

    logic [15:0]         near_lane_reg;
    logic [15:0]         near_exit_reg;
    logic signed [31:0]  offset_x_reg;
    logic signed [31:0]  offset_y_reg;

    logic                cmd_take;
    logic                res_take;
    logic                slot_free;
    logic                load_res;
    logic                last_issue;
    logic                cfg_wr;
    rpl_pkg::reg_idx_t   cfg_idx;

    logic                wr_en;
    rpl_pkg::point_t     wr_data;
    rpl_pkg::point_t     rd_data;
    rpl_pkg::scan_ctrl_t scan_ctrl;
    rpl_pkg::scan_stat_t scan_stat;

    assign cmd_take   = cmd_valid && !cmd_stall;
    assign res_take   = res_valid_reg && !res_stall;
    assign slot_free  = !res_valid_reg || !res_stall;
    assign last_issue = (rd_addr_reg + CW'(1)) == count_reg;

    // register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = rpl_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        unique case (cfg_idx)
            rpl_pkg::REG_NEAR_LANE: prdata = {16'd0, near_lane_reg};
            rpl_pkg::REG_NEAR_EXIT: prdata = {16'd0, near_exit_reg};
            rpl_pkg::REG_OFFSET_X:  prdata = offset_x_reg;
            rpl_pkg::REG_OFFSET_Y:  prdata = offset_y_reg;
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_lane_reg <= rpl_pkg::NEAR_DIST_RESET;
            near_exit_reg <= rpl_pkg::NEAR_DIST_RESET;
            offset_x_reg  <= 32'sd0;
            offset_y_reg  <= 32'sd0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                rpl_pkg::REG_NEAR_LANE: near_lane_reg <= pwdata[15:0];
                rpl_pkg::REG_NEAR_EXIT: near_exit_reg <= pwdata[15:0];
                rpl_pkg::REG_OFFSET_X:  offset_x_reg  <= pwdata;
                rpl_pkg::REG_OFFSET_Y:  offset_y_reg  <= pwdata;
                default:                ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpl_pkg::ST_IDLE:
            begin
                if (cmd_take && (cmd.operation == rpl_pkg::OP_QUERY))
                begin
                    state_next = (count_reg == '0) ? rpl_pkg::ST_DRAIN : rpl_pkg::ST_SCAN;
                end
            end
            rpl_pkg::ST_SCAN:
            begin
                if (last_issue)
                begin
                    state_next = rpl_pkg::ST_DRAIN;
                end
            end
            rpl_pkg::ST_DRAIN:
            begin
                if (!scan_stat.busy)
                begin
                    state_next = rpl_pkg::ST_DONE;
                end
            end
            rpl_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = rpl_pkg::ST_IDLE;
                end
            end
            default: state_next = rpl_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_stall       = 1'b1;
        scan_ctrl.init  = 1'b0;
        scan_ctrl.rd_en = 1'b0;
        wr_en           = 1'b0;
        load_res        = 1'b0;
        count_next      = count_reg;
        rd_addr_next    = rd_addr_reg;
        unique case (state_reg)
            rpl_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    case (cmd.operation)
                        rpl_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        rpl_pkg::OP_APPEND:
                        begin
                            if (count_reg < CW'(MAX_POINTS))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        rpl_pkg::OP_QUERY:
                        begin
                            scan_ctrl.init = 1'b1;
                            rd_addr_next   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            rpl_pkg::ST_SCAN:
            begin
                scan_ctrl.rd_en = 1'b1;
                rd_addr_next    = rd_addr_reg + CW'(1);
            end
            rpl_pkg::ST_DRAIN: ;
            rpl_pkg::ST_DONE:
            begin
                load_res = slot_free;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load_res)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_take)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpl_pkg::ST_IDLE;
            count_reg     <= '0;
            rd_addr_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_addr_reg   <= rd_addr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_reg <= scan_stat.result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        wr_data.x       = cmd.coord_x;
        wr_data.y       = cmd.coord_y;
        wr_data.heading = cmd.heading_in;
        wr_data.is_exit = cmd.exit_flag;
    end

    rpl_point_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_point_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (scan_ctrl.rd_en),
        .rd_addr (rd_addr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    rpl_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .coord_x   (cmd.coord_x),
        .coord_y   (cmd.coord_y),
        .offset_x  (offset_x_reg),
        .offset_y  (offset_y_reg),
        .near_lane (near_lane_reg),
        .near_exit (near_exit_reg),
        .rd_data   (rd_data),
        .stat      (scan_stat)
    );

endmodule

@@ hw/rtl/rpl_checker.sv @@
// ----------------------------------------------------------------------------
// rpl_checker
// Port-level checks for the road proximity lookup, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "road_proximity_lookup_top_macros.svh"

module rpl_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_stall,
    input rpl_pkg::cmd_t              cmd,
    input logic                       res_valid,
    input logic                       res_stall,
    input rpl_pkg::res_t              res
);

    `RPL_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))
    `RPL_ASSERT_NOW(a_no_road_zero_heading, res_valid && !res.road_found, res.road_heading == 16'sd0)
    `RPL_ASSERT_NEXT(a_query_busy, cmd_valid && !cmd_stall && cmd.operation == rpl_pkg::OP_QUERY, cmd_stall)
    `RPL_ASSERT_NEXT(a_update_single_cycle, cmd_valid && !cmd_stall && cmd.operation != rpl_pkg::OP_QUERY, !cmd_stall)

endmodule

bind road_proximity_lookup_top rpl_checker u_rpl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

@@ verif/rpl_lookup_checker.sv @@
// ----------------------------------------------------------------------------
// rpl_lookup_checker
// Watches the command, result and register channels of the road proximity
// lookup, keeps its own copy of the point table and thresholds, works out the
// answer to every accepted query and compares it field by field with the
// results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpl_lookup_checker #(
    parameter int unsigned MAX_POINTS = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    input  logic                       cmd_stall,
    input  rpl_pkg::cmd_t              cmd,
    input  logic                       res_valid,
    input  logic                       res_stall,
    input  rpl_pkg::res_t              res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [rpl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output int                         answers_due,
    output int                         mismatches
);

    localparam logic [63:0] SEARCH_BOUND_SQ = 64'd4096000000;

    logic [15:0]        lane_dist;
    logic [15:0]        exit_dist;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    rpl_pkg::point_t    road_pts [MAX_POINTS];
    int unsigned        road_cnt;
    rpl_pkg::res_t      answer_q [$];

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns lookup checker: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [33:0] abs_gap(logic [31:0] p, logic [32:0] q);
        logic [33:0] d;
        d = {{2{p[31]}}, p} - {q[32], q};
        return d[33] ? (~d + 34'd1) : d;
    endfunction

    // saturate to all ones when the square sum leaves 64 bits
    function automatic logic [63:0] square_dist(logic [33:0] ax, logic [33:0] ay);
        logic [63:0] sx;
        logic [63:0] sy;
        logic [64:0] total;
        if (ax[33:32] != 2'b00 || ay[33:32] != 2'b00)
        begin
            return '1;
        end
        sx    = 64'(ax[31:0]) * 64'(ax[31:0]);
        sy    = 64'(ay[31:0]) * 64'(ay[31:0]);
        total = {1'b0, sx} + {1'b0, sy};
        return total[64] ? '1 : total[63:0];
    endfunction

    function automatic rpl_pkg::res_t nearest_road(logic [31:0] x, logic [31:0] y);
        logic [32:0]   qx;
        logic [32:0]   qy;
        logic [63:0]   lane2;
        logic [63:0]   exit2;
        logic [63:0]   radius2;
        logic [63:0]   best;
        logic [63:0]   d2;
        rpl_pkg::res_t r;
        qx      = {x[31], x} + {shift_x[31], shift_x};
        qy      = {y[31], y} + {shift_y[31], shift_y};
        lane2   = 64'(lane_dist) * 64'(lane_dist);
        exit2   = 64'(exit_dist) * 64'(exit_dist);
        radius2 = (lane2 > exit2) ? lane2 : exit2;
        best    = SEARCH_BOUND_SQ;
        r       = '0;
        for (int unsigned i = 0; i < road_cnt; i++)
        begin
            d2 = square_dist(abs_gap(road_pts[i].x, qx), abs_gap(road_pts[i].y, qy));
            if (d2 < radius2)
            begin
                if (d2 < best)
                begin
                    best           = d2;
                    r.road_found   = 1'b1;
                    r.road_heading = road_pts[i].heading;
                end
                if ((road_pts[i].is_exit && d2 < exit2) || d2 < lane2)
                begin
                    r.is_close = 1'b1;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rpl_pkg::res_t want;
        if (!rst_n)
        begin
            lane_dist = rpl_pkg::NEAR_DIST_RESET;
            exit_dist = rpl_pkg::NEAR_DIST_RESET;
            shift_x   = '0;
            shift_y   = '0;
            road_cnt  = 0;
            answer_q.delete();
            mismatches  = 0;
            answers_due <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (answer_q.size() == 0)
                begin
                    report_mismatch("unexpected result, is_close", res.is_close, 0);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (res.is_close !== want.is_close)
                        report_mismatch("is_close", res.is_close, want.is_close);
                    if (res.road_found !== want.road_found)
                        report_mismatch("road_found", res.road_found, want.road_found);
                    if (res.road_heading !== want.road_heading)
                        report_mismatch("road_heading", res.road_heading, want.road_heading);
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                case (cmd.operation)
                    rpl_pkg::OP_CLEAR:  road_cnt = 0;
                    rpl_pkg::OP_APPEND:
                    begin
                        if (road_cnt < MAX_POINTS)
                        begin
                            road_pts[road_cnt] = '{cmd.coord_x, cmd.coord_y,
                                                   cmd.heading_in, cmd.exit_flag};
                            road_cnt++;
                        end
                    end
                    rpl_pkg::OP_QUERY:
                        answer_q.push_back(nearest_road(cmd.coord_x, cmd.coord_y));
                    default:   ;
                endcase
            end
            if (psel && penable && pwrite && pready)
            begin
                case (rpl_pkg::reg_idx_t'(paddr[3:2]))
                    rpl_pkg::REG_NEAR_LANE: lane_dist = pwdata[15:0];
                    rpl_pkg::REG_NEAR_EXIT: exit_dist = pwdata[15:0];
                    rpl_pkg::REG_OFFSET_X:  shift_x   = pwdata;
                    rpl_pkg::REG_OFFSET_Y:  shift_y   = pwdata;
                    default:                ;
                endcase
            end
            answers_due <= answer_q.size();
        end
    end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives the road proximity lookup with directed corner items, a larger table
// with tied nearest points, and random phases of clear, append, query and
// unused-code items under several threshold and offset settings, with random
// idling on both channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int unsigned  MAX_PTS       = 4096;
    localparam int           HOLD_CYCLES   = 300;
    localparam int           QUIET_LIMIT   = 20000;
    localparam int           SETTLE_CYCLES = 16;
    localparam int           PHASES        = 8;
    localparam int           PHASE_ITEMS   = 10;
    localparam int           FILL_POINTS   = 24;
    localparam int           SPAN          = 4000;
    localparam rpl_pkg::op_t OP_SPARE      = rpl_pkg::op_t'(2'b11);

    logic                       clk;
    logic                       rst_n;
    logic                       cmd_valid;
    logic                       cmd_stall;
    rpl_pkg::cmd_t              cmd;
    logic                       res_valid;
    logic                       res_stall;
    rpl_pkg::res_t              res;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [rpl_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    int                         answers_due;
    int                         mismatches;
    logic                       calm;
    logic                       hold_go;
    int                         quiet_cycles;

    road_proximity_lookup_top #(
        .MAX_POINTS (MAX_PTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    rpl_lookup_checker #(
        .MAX_POINTS (MAX_PTS)
    ) u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .answers_due (answers_due),
        .mismatches  (mismatches)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : result_sink
        int held;
        held      = 0;
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && held < HOLD_CYCLES)
            begin
                res_stall <= 1'b1;
                held++;
            end
            else if (calm)
                res_stall <= 1'b0;
            else
                res_stall <= ($urandom_range(99) < 37);
        end
    end

    function automatic logic signed [31:0] rnd_near(int centre, int half);
        return centre + int'($urandom_range(2 * half)) - half;
    endfunction

    function automatic logic signed [15:0] rand_heading();
        int h;
        h = int'($urandom_range(51472)) - 25736;
        return h[15:0];
    endfunction

    function automatic rpl_pkg::cmd_t road_cmd(rpl_pkg::op_t op, logic signed [31:0] x,
                                               logic signed [31:0] y,
                                               logic signed [15:0] h, logic e);
        rpl_pkg::cmd_t c;
        c.operation  = op;
        c.coord_x    = x;
        c.coord_y    = y;
        c.heading_in = h;
        c.exit_flag  = e;
        return c;
    endfunction

    task automatic send_item(rpl_pkg::cmd_t c);
        while (!calm && $urandom_range(99) < 37)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic add_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [15:0] h, logic e);
        send_item(road_cmd(rpl_pkg::OP_APPEND, x, y, h, e));
    endtask

    task automatic ask_at(logic signed [31:0] x, logic signed [31:0] y);
        send_item(road_cmd(rpl_pkg::OP_QUERY, x, y, rand_heading(), 1'($urandom_range(1))));
    endtask

    task automatic clear_table();
        send_item(road_cmd(rpl_pkg::OP_CLEAR, $urandom, $urandom, rand_heading(),
                           1'($urandom_range(1))));
    endtask

    // drop valid, wait for every answer, then idle before returning
    task automatic settle_block();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (answers_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(rpl_pkg::reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic write_config(logic [15:0] lane_th, logic [15:0] exit_th,
                                logic [31:0] ox, logic [31:0] oy);
        put_reg(rpl_pkg::REG_NEAR_LANE, {16'd0, lane_th});
        put_reg(rpl_pkg::REG_NEAR_EXIT, {16'd0, exit_th});
        put_reg(rpl_pkg::REG_OFFSET_X, ox);
        put_reg(rpl_pkg::REG_OFFSET_Y, oy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic directed_items();
        ask_at(0, 0);
        send_item(road_cmd(OP_SPARE, 0, 0, 0, 1'b0));
        add_point(0, 0, 16'sd25736, 1'b0);
        add_point(100, 0, -16'sd25736, 1'b1);
        add_point(0, 255, 16'sd1, 1'b0);
        ask_at(0, 0);
        ask_at(50, 0);
        ask_at(64, 0);
        ask_at(0, -128);
        ask_at(0, -127);
        add_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh1234, 1'b1);
        add_point(32'sh80000000, 32'sh80000000, -16'sh0FED, 1'b0);
        ask_at(32'sh80000000, 32'sh80000000);
        ask_at(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        settle_block();
        write_config(16'hFFFF, 16'h0000, 32'h7FFFFFFF, 32'h80000000);
        ask_at(32'sh80000000, 32'sh7FFFFFFF);
        ask_at(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        settle_block();
        write_config(16'd0, 16'd300, 32'd0, 32'd0);
        ask_at(100, 250);
        ask_at(0, 0);
        clear_table();
        ask_at(0, 0);
    endtask

    task automatic fill_table();
        settle_block();
        write_config(16'd200, 16'd300, 32'd0, 32'd0);
        clear_table();
        for (int i = 0; i < FILL_POINTS; i++)
            add_point(rnd_near(-100000, 50000), rnd_near(100000, 50000), rand_heading(),
                      1'($urandom_range(1)));
        add_point(7000, 7000, 16'sd777, 1'b0);
        add_point(7010, 7000, -16'sd777, 1'b1);
        add_point(7010, 7000, -16'sd778, 1'b0);
        ask_at(7010, 7000);
        ask_at(20000, 20000);
        clear_table();
    endtask

    task automatic random_phase(int p);
        logic [15:0]        lane_th;
        logic [15:0]        exit_th;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        int                 kind;
        case (p)
            0:
            begin
                lane_th = 16'h0000;
                exit_th = 16'h0000;
            end
            1:
            begin
                lane_th = 16'hFFFF;
                exit_th = 16'hFFFF;
            end
            2:
            begin
                lane_th = 16'h0000;
                exit_th = 16'hFFFF;
            end
            3:
            begin
                lane_th = 16'hFFFF;
                exit_th = 16'h0000;
            end
            default:
            begin
                lane_th = 16'($urandom_range(3000));
                exit_th = 16'($urandom_range(3000));
            end
        endcase
        if (p == 5)
        begin
            ox = $urandom;
            oy = $urandom;
        end
        else if (p == 6)
        begin
            ox = 32'sh80000000;
            oy = 32'sh7FFFFFFF;
        end
        else
        begin
            ox = rnd_near(0, 200000);
            oy = rnd_near(0, 200000);
        end
        if (p == 7)
        begin
            bx = $urandom;
            by = $urandom;
        end
        else
        begin
            bx = rnd_near(0, 1 << 29);
            by = rnd_near(0, 1 << 29);
        end
        settle_block();
        write_config(lane_th, exit_th, ox, oy);
        calm    <= (p == 2);
        hold_go <= (p == 4) || hold_go;
        clear_table();
        if (p == 4)
        begin
            ask_at(bx - ox, by - oy);
            ask_at(bx - ox, by - oy);
        end
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
                add_point(rnd_near(bx, SPAN), rnd_near(by, SPAN), rand_heading(),
                          1'($urandom_range(1)));
            else if (kind < 82)
                ask_at(rnd_near(bx - ox, SPAN), rnd_near(by - oy, SPAN));
            else
                send_item(road_cmd(rpl_pkg::op_t'(2'($urandom_range(3))), $urandom,
                                   $urandom, rand_heading(), 1'($urandom_range(1))));
        end
    endtask

    initial
    begin : stimulus
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        calm      = 1'b0;
        hold_go   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        fill_table();
        for (int p = 0; p < PHASES; p++)
            random_phase(p);
        settle_block();
        if (mismatches == 0 && answers_due == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
